[hdl/mlx_pkg.sv]
// Shared types and constants for the message-language lexer.
// Holds token kind codes, source byte codes and the run record that passes
// from the classifier through the queue to the output stage.
package mlx_pkg;

   // Token kind codes
   localparam logic [4:0] K_SYMBOL    = 5'd0;
   localparam logic [4:0] K_KEYWORD   = 5'd1;
   localparam logic [4:0] K_IDENT     = 5'd2;
   localparam logic [4:0] K_NUMBER    = 5'd3;
   localparam logic [4:0] K_STRING    = 5'd4;
   localparam logic [4:0] K_CHAR      = 5'd5;
   localparam logic [4:0] K_AT_LBRACK = 5'd6;
   localparam logic [4:0] K_AT_LBRACE = 5'd7;
   localparam logic [4:0] K_RW_SLOT   = 5'd8;
   localparam logic [4:0] K_RO_SLOT   = 5'd9;
   localparam logic [4:0] K_SEMI      = 5'd10;
   localparam logic [4:0] K_COLON     = 5'd11;
   localparam logic [4:0] K_PIPE      = 5'd12;
   localparam logic [4:0] K_LPAREN    = 5'd13;
   localparam logic [4:0] K_RPAREN    = 5'd14;
   localparam logic [4:0] K_LBRACK    = 5'd15;
   localparam logic [4:0] K_RBRACK    = 5'd16;
   localparam logic [4:0] K_LBRACE    = 5'd17;
   localparam logic [4:0] K_RBRACE    = 5'd18;
   localparam logic [4:0] K_END       = 5'd19;
   localparam logic [4:0] K_ERROR     = 5'd20;

   // Source byte codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Run queue geometry
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   // Results caused by one source transaction (one or two kinds)
   typedef struct packed {
      logic [4:0] kind0;
      logic [4:0] kind1;
      logic       two;
   } run_type;

endpackage

[hdl/message_language_lexer.sv]
// Message-language lexer: takes one source byte (or an end mark) per
// transaction and returns token kinds. A byte is accepted every cycle while
// the four-entry run queue has room; its results pass through a queue entry
// and then the output register. Results leave at one per cycle through the
// output register while rsp_ready is high, so a byte that causes two results
// (token end plus a one-byte token or end) has them leave in turn.
// Sustained output never exceeds one result per byte, so with rsp_ready held
// high the queue does not fill and req_ready stays high; only a stalled result
// side fills the queue and then holds req_ready low. No reset sweep.
// Depends on mlx_pkg, mlx_front, mlx_queue and mlx_back.
module message_language_lexer
   import mlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_is_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_token_kind,
   output logic       rsp_last_of_run
);

   logic    push_valid;
   logic    push_ready;
   run_type push_run;
   logic    head_valid;
   run_type head_run;
   logic    pop;

   // Classifier
   mlx_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_code(req_char_code),
      .req_is_end   (req_is_end),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_run     (push_run)
   );

   // Run queue
   mlx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_run  (push_run),
      .pop       (pop),
      .head_valid(head_valid),
      .head_run  (head_run)
   );

   // Output stage
   mlx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_run       (head_run),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_kind (rsp_token_kind),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // End and error always close a run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == K_END || rsp_token_kind == K_ERROR)
      |-> rsp_last_of_run)
      else $error("end or error kind not marked last");

   // Only a pending symbol, identifier or number leads a two-kind run
   a_two_lead: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_run.two
      |-> (push_run.kind0 == K_SYMBOL || push_run.kind0 == K_IDENT ||
           push_run.kind0 == K_NUMBER))
      else $error("two-kind run with bad leading kind");

   // The second kind of a run follows right after the first is taken
   a_second_ready: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_valid && rsp_ready && !rsp_last_of_run)
      |-> rsp_valid)
      else $error("second kind of run missing");

   // Never pop an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty run queue");

endmodule

[hdl/mlx_front.sv]
// Classifier for the message-language lexer: holds lexer mode and error flag.
// Turns each source transaction into a run of one or two token kinds, or into none.
// Depends on mlx_pkg.
module mlx_front
   import mlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_is_end,
   input  logic       push_ready,
   output logic       push_valid,
   output run_type    push_run
);

   typedef enum logic [9:0] {
      M_IDLE       = 10'b0000000001,
      M_COMMENT    = 10'b0000000010,
      M_SYMBOL     = 10'b0000000100,
      M_IDENT      = 10'b0000001000,
      M_NUMBER     = 10'b0000010000,
      M_STRING     = 10'b0000100000,
      M_CHAR_BODY  = 10'b0001000000,
      M_CHAR_CLOSE = 10'b0010000000,
      M_AT         = 10'b0100000000,
      M_LT         = 10'b1000000000
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       hit;
      logic [4:0] kind;
      logic       fail;
   } idle_res_type;

   // Byte seen between tokens: skip whitespace, start a token or comment, or emit a one-byte token or error
   function automatic idle_res_type idle_byte(input logic [7:0] c);
      idle_res_type r;
      r.mode = M_IDLE;
      r.hit  = 1'b0;
      r.kind = K_ERROR;
      r.fail = 1'b0;
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
         r.mode = M_IDLE;
      end else if (c == CH_HASH) begin
         r.mode = M_COMMENT;
      end else if (c == CH_DOLLAR) begin
         r.mode = M_SYMBOL;
      end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
         r.mode = M_IDENT;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.mode = M_NUMBER;
      end else begin
         unique case (c)
            CH_DQUOTE: r.mode = M_STRING;
            CH_SQUOTE: r.mode = M_CHAR_BODY;
            CH_AT:     r.mode = M_AT;
            CH_LT:     r.mode = M_LT;
            CH_EQUAL:  begin r.hit = 1'b1; r.kind = K_RO_SLOT; end
            CH_SEMI:   begin r.hit = 1'b1; r.kind = K_SEMI;    end
            CH_COLON:  begin r.hit = 1'b1; r.kind = K_COLON;   end
            CH_PIPE:   begin r.hit = 1'b1; r.kind = K_PIPE;    end
            CH_LPAREN: begin r.hit = 1'b1; r.kind = K_LPAREN;  end
            CH_RPAREN: begin r.hit = 1'b1; r.kind = K_RPAREN;  end
            CH_LBRACK: begin r.hit = 1'b1; r.kind = K_LBRACK;  end
            CH_RBRACK: begin r.hit = 1'b1; r.kind = K_RBRACK;  end
            CH_LBRACE: begin r.hit = 1'b1; r.kind = K_LBRACE;  end
            CH_RBRACE: begin r.hit = 1'b1; r.kind = K_RBRACE;  end
            default:   begin r.hit = 1'b1; r.kind = K_ERROR; r.fail = 1'b1; end
         endcase
      end
      return r;
   endfunction

   mode_type     mode_ff, mode_in;
   logic         err_ff, err_in;
   logic         accept;
   idle_res_type ib;
   logic         e0_v, e1_v;
   logic [4:0]   e0_k, e1_k;
   logic [4:0]   pend_kind;
   logic         more;
   logic         is_dig;
   logic         is_alp;

   assign accept    = req_valid && push_ready;
   assign req_ready = push_ready;

   // Byte classes
   always_comb begin
      ib     = idle_byte(req_char_code);
      is_dig = (req_char_code >= 8'h30 && req_char_code <= 8'h39);
      is_alp = (req_char_code >= 8'h61 && req_char_code <= 8'h7A) ||
               (req_char_code >= 8'h41 && req_char_code <= 8'h5A);
   end

   // Next mode and emitted kinds
   always_comb begin
      mode_in   = mode_ff;
      err_in    = err_ff;
      e0_v      = 1'b0;
      e0_k      = K_ERROR;
      e1_v      = 1'b0;
      e1_k      = K_ERROR;
      pend_kind = K_NUMBER;
      more      = is_dig;
      if (mode_ff == M_SYMBOL) begin
         pend_kind = K_SYMBOL;
         more      = is_dig || is_alp;
      end else if (mode_ff == M_IDENT) begin
         pend_kind = K_IDENT;
         more      = is_dig || is_alp;
      end
      if (err_ff) begin
         mode_in = M_IDLE;
         if (req_is_end) begin
            e0_v = 1'b1;
            e0_k = K_ERROR;
         end
      end else begin
         unique case (mode_ff)
            M_COMMENT: begin
               if (req_is_end) begin
                  e0_v    = 1'b1;
                  e0_k    = K_END;
                  mode_in = M_IDLE;
               end else if (req_char_code == CH_LF) begin
                  mode_in = M_IDLE;
               end
            end
            M_SYMBOL, M_IDENT, M_NUMBER: begin
               if (req_is_end) begin
                  e0_v    = 1'b1;
                  e0_k    = pend_kind;
                  e1_v    = 1'b1;
                  e1_k    = K_END;
                  mode_in = M_IDLE;
               end else if (more) begin
                  mode_in = mode_ff;
               end else if (mode_ff == M_IDENT && req_char_code == CH_COLON) begin
                  e0_v    = 1'b1;
                  e0_k    = K_KEYWORD;
                  mode_in = M_IDLE;
               end else begin
                  e0_v    = 1'b1;
                  e0_k    = pend_kind;
                  e1_v    = ib.hit;
                  e1_k    = ib.kind;
                  mode_in = ib.mode;
                  err_in  = ib.fail;
               end
            end
            M_STRING: begin
               if (req_is_end) begin
                  e0_v    = 1'b1;
                  e0_k    = K_ERROR;
                  err_in  = 1'b1;
                  mode_in = M_IDLE;
               end else if (req_char_code == CH_DQUOTE) begin
                  e0_v    = 1'b1;
                  e0_k    = K_STRING;
                  mode_in = M_IDLE;
               end
            end
            M_CHAR_BODY: begin
               if (req_is_end) begin
                  e0_v    = 1'b1;
                  e0_k    = K_ERROR;
                  err_in  = 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  mode_in = M_CHAR_CLOSE;
               end
            end
            M_CHAR_CLOSE: begin
               e0_v    = 1'b1;
               mode_in = M_IDLE;
               if (!req_is_end && req_char_code == CH_SQUOTE) begin
                  e0_k = K_CHAR;
               end else begin
                  e0_k   = K_ERROR;
                  err_in = 1'b1;
               end
            end
            M_AT: begin
               e0_v    = 1'b1;
               mode_in = M_IDLE;
               if (!req_is_end && req_char_code == CH_LBRACK) begin
                  e0_k = K_AT_LBRACK;
               end else if (!req_is_end && req_char_code == CH_LBRACE) begin
                  e0_k = K_AT_LBRACE;
               end else begin
                  e0_k   = K_ERROR;
                  err_in = 1'b1;
               end
            end
            M_LT: begin
               e0_v    = 1'b1;
               mode_in = M_IDLE;
               if (!req_is_end && req_char_code == CH_MINUS) begin
                  e0_k = K_RW_SLOT;
               end else begin
                  e0_k   = K_ERROR;
                  err_in = 1'b1;
               end
            end
            default: begin
               // idle, and any stray code
               if (req_is_end) begin
                  e0_v    = 1'b1;
                  e0_k    = K_END;
                  mode_in = M_IDLE;
               end else begin
                  e0_v    = ib.hit;
                  e0_k    = ib.kind;
                  mode_in = ib.mode;
                  err_in  = ib.fail;
               end
            end
         endcase
      end
   end

   // Run record toward the queue
   assign push_valid     = accept && e0_v;
   assign push_run.kind0 = e0_k;
   assign push_run.kind1 = e1_k;
   assign push_run.two   = e1_v;

   // Lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         err_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         err_ff  <= err_in;
      end
   end

endmodule

[hdl/mlx_queue.sv]
// Short run queue between the lexer classifier and the output stage.
// Stores run records in a small register array. Depends on mlx_pkg.
module mlx_queue
   import mlx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  run_type push_run,
   input  logic    pop,
   output logic    head_valid,
   output run_type head_run
);

   run_type        mem [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign push_ready = (count_ff != QDEPTH[QAW:0]);
   assign head_valid = (count_ff != '0);
   assign head_run   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_run;
      end
   end

endmodule

[hdl/mlx_back.sv]
// Output stage of the message-language lexer: unpacks run records into
// single token transactions held in an output register. Depends on mlx_pkg.
module mlx_back
   import mlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  run_type    head_run,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_token_kind,
   output logic       rsp_last_of_run
);

   logic       valid_ff, valid_in;
   logic [4:0] kind_ff, kind_in;
   logic       last_ff, last_in;
   logic       half_ff, half_in;
   logic       can_load;
   logic       load;

   assign can_load = !valid_ff || rsp_ready;
   assign load     = can_load && head_valid;

   // Pick the next kind of the head run; pop as its final kind is loaded into the output register
   always_comb begin
      kind_in  = half_ff ? head_run.kind1 : head_run.kind0;
      last_in  = half_ff || !head_run.two;
      pop      = load && last_in;
      half_in  = half_ff;
      valid_in = valid_ff;
      if (load) begin
         half_in  = !last_in;
         valid_in = 1'b1;
      end else if (can_load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_last_of_run = last_ff;

endmodule
